// File: rtl/tsp_pkg.sv
// Package for the tilemap scroll pixel fetch unit.
// Holds field widths, action and register codes, reset values and the stage control type.
// Depends on nothing.
package tsp_pkg;

	// Field widths of the channels and registers.
	localparam int ACTION_W     = 2;
	localparam int ADDR_W       = 16;
	localparam int DATA_W       = 16;
	localparam int COORD_W      = 9;
	localparam int COLOR_W      = 16;
	localparam int FRAME_W      = 17;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int TILE_SHIFT_W = 3;
	localparam int MAP_DIM_W    = 13;
	localparam int SCROLL_W     = 16;
	localparam int TILE_NUM_W   = 8;

	// Internal widths.
	localparam int WORLD_W      = 17;  // screen coordinate plus signed scroll
	localparam int SUB_W        = 4;   // pixel position inside a tile of up to 16 pixels
	localparam int MAP_IDX_W    = 26;  // row times columns plus column, 13 by 13 bits
	localparam int TILE_IDX_W   = 16;  // tile number, row and column inside the tile
	localparam int FRAME_PROD_W = 21;  // 9-bit row times an 11-bit width plus column

	localparam logic [TILE_SHIFT_W-1:0] MAX_TILE_SHIFT = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [TILE_SHIFT_W-1:0] RST_TILE_SHIFT  = 3'd4;
	localparam logic [MAP_DIM_W-1:0]    RST_MAP_COLUMNS = 13'd64;
	localparam logic [MAP_DIM_W-1:0]    RST_MAP_ROWS    = 13'd64;
	localparam logic [SCROLL_W-1:0]     RST_SCROLL      = 16'd0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_MAP_WRITE  = 2'd0,
		ACT_TILE_WRITE = 2'd1,
		ACT_RENDER     = 2'd2,
		ACT_IDLE       = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TILE_SHIFT  = 3'd0,
		REG_MAP_COLUMNS = 3'd1,
		REG_MAP_ROWS    = 3'd2,
		REG_HSCROLL     = 3'd3,
		REG_VSCROLL     = 3'd4
	} reg_index_t;

	// Control and payload that travel with a word down the pipeline.
	typedef struct packed {
		action_t                act;
		logic                   hit;
		logic [ADDR_W-1:0]      addr;
		logic [DATA_W-1:0]      data;
		logic [SUB_W-1:0]       px;
		logic [SUB_W-1:0]       py;
		logic [FRAME_W-1:0]     frame;
	} pix_ctl_t;

endpackage

// File: rtl/tilemap_scroll_pixel_fetch_unit.sv
// Top level of the tilemap scroll pixel fetch unit: map store, tile pixel store and pipeline.
// Depends on tsp_pkg.
//
// Usage. Every input word carries an action: a map store write, a tile pixel store write,
// a render request for one screen pixel, or nothing. Every accepted word yields exactly one
// output word, in order. For a render word whose screen position is on the screen and whose
// world position (screen position plus the scroll registers) falls inside the map, the output
// word holds the tile pixel colour, the frame buffer address row * SCREEN_WIDTH + column and a
// set write_enable; every other word gives an all-zero output word.
// Throughput is one word per cycle while in_stall is low. The pipeline depth is set by the two
// dependent memory reads (map store, then tile pixel store), each of which sits behind a
// three-stage index reduction (multiply by reciprocal, subtract, correct).
// The output side has an output register and a skid register. A stalled output word is
// held steady; the pipeline keeps moving until the skid register fills, and only then is
// in_stall raised, so in_stall comes straight from a flop.
// Configuration is written through cfg_write, cfg_index and cfg_data while no word is in
// flight. Reset clears the pipeline, returns the registers to 16-pixel tiles on a 64 by 64
// map with no scroll, and leaves both stores undefined until written.
module tilemap_scroll_pixel_fetch_unit #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 320,
	parameter int MAP_ENTRIES   = 4096,
	parameter int TILE_WORDS    = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tsp_pkg::ACTION_W-1:0]     action,
	input  logic [tsp_pkg::ADDR_W-1:0]       store_address,
	input  logic [tsp_pkg::DATA_W-1:0]       store_data,
	input  logic [tsp_pkg::COORD_W-1:0]      screen_column,
	input  logic [tsp_pkg::COORD_W-1:0]      screen_row,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tsp_pkg::COLOR_W-1:0]      pixel_color,
	output logic [tsp_pkg::FRAME_W-1:0]      frame_address,
	output logic                             write_enable,
	input  logic                             cfg_write,
	input  logic [tsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tsp_pkg::*;

	// Store address widths and the constants of the modulo reductions. An index below
	// 2^W is reduced by multiplying by floor(2^W / depth); the quotient estimate is at
	// most one short, so one conditional subtract finishes the remainder.
	localparam int MapAw     = $clog2(MAP_ENTRIES);
	localparam int TileAw    = $clog2(TILE_WORDS);
	localparam int MapRecipW  = MAP_IDX_W - MapAw + 1;
	localparam int TileRecipW = TILE_IDX_W - TileAw + 1;
	localparam int MapProdW  = MAP_IDX_W + MapRecipW;
	localparam int TileProdW = TILE_IDX_W + TileRecipW;
	localparam logic [MapRecipW-1:0] MapRecip =
		MapRecipW'((64'd1 << MAP_IDX_W) / 64'(MAP_ENTRIES));
	localparam logic [TileRecipW-1:0] TileRecip =
		TileRecipW'((64'd1 << TILE_IDX_W) / 64'(TILE_WORDS));
	localparam logic [MapAw:0]  MapDepth  = (MapAw + 1)'(MAP_ENTRIES);
	localparam logic [TileAw:0] TileDepth = (TileAw + 1)'(TILE_WORDS);
	localparam int Stages = 8;

	// Configuration registers.
	logic [TILE_SHIFT_W-1:0] tile_shift_q;
	logic [MAP_DIM_W-1:0]    map_columns_q;
	logic [MAP_DIM_W-1:0]    map_rows_q;
	logic [SCROLL_W-1:0]     hscroll_q;
	logic [SCROLL_W-1:0]     vscroll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_shift_q  <= RST_TILE_SHIFT;
			map_columns_q <= RST_MAP_COLUMNS;
			map_rows_q    <= RST_MAP_ROWS;
			hscroll_q     <= RST_SCROLL;
			vscroll_q     <= RST_SCROLL;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_TILE_SHIFT:  tile_shift_q  <= cfg_data[TILE_SHIFT_W-1:0];
				REG_MAP_COLUMNS: map_columns_q <= cfg_data[MAP_DIM_W-1:0];
				REG_MAP_ROWS:    map_rows_q    <= cfg_data[MAP_DIM_W-1:0];
				REG_HSCROLL:     hscroll_q     <= cfg_data[SCROLL_W-1:0];
				REG_VSCROLL:     vscroll_q     <= cfg_data[SCROLL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Tile edges larger than 16 pixels are held at 16.
	logic [TILE_SHIFT_W-1:0] sh;
	assign sh = (tile_shift_q > MAX_TILE_SHIFT) ? MAX_TILE_SHIFT : tile_shift_q;

	// The whole pipeline moves together; it halts only while the skid register is full.
	logic              en;
	logic              skid_valid_q;
	logic [Stages-1:0] stage_valid_q;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else if (en) begin
			stage_valid_q <= {stage_valid_q[Stages-2:0], in_valid};
		end
	end

	// Stage 1: capture the word and form the world position.
	pix_ctl_t             ctl_s1;
	logic [COORD_W-1:0]   sx_s1;
	logic [COORD_W-1:0]   sy_s1;
	logic [WORLD_W-1:0]   wx_s1;
	logic [WORLD_W-1:0]   wy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.act   <= action_t'(action);
			ctl_s1.hit   <= 1'b0;
			ctl_s1.addr  <= store_address;
			ctl_s1.data  <= store_data;
			ctl_s1.px    <= '0;
			ctl_s1.py    <= '0;
			ctl_s1.frame <= '0;
			sx_s1        <= screen_column;
			sy_s1        <= screen_row;
			wx_s1        <= WORLD_W'(screen_column) + {hscroll_q[SCROLL_W-1], hscroll_q};
			wy_s1        <= WORLD_W'(screen_row) + {vscroll_q[SCROLL_W-1], vscroll_q};
		end
	end

	// Stage 2: bounds test, split into tile and in-tile position, map row product and
	// frame buffer address.
	logic [WORLD_W-1:0]      wlim;
	logic [WORLD_W-1:0]      hlim;
	logic                    x_inside;
	logic                    y_inside;
	logic                    on_screen;
	logic [WORLD_W-2:0]      mx_full;
	logic [WORLD_W-2:0]      my_full;
	logic [SUB_W-1:0]        sub_mask;
	logic [FRAME_PROD_W-1:0] frame_full;

	assign wlim      = WORLD_W'(map_columns_q) << sh;
	assign hlim      = WORLD_W'(map_rows_q) << sh;
	assign x_inside  = !wx_s1[WORLD_W-1] && ({1'b0, wx_s1[WORLD_W-2:0]} < wlim);
	assign y_inside  = !wy_s1[WORLD_W-1] && ({1'b0, wy_s1[WORLD_W-2:0]} < hlim);
	assign on_screen = (32'(sx_s1) < 32'(SCREEN_WIDTH)) && (32'(sy_s1) < 32'(SCREEN_HEIGHT));
	assign mx_full   = wx_s1[WORLD_W-2:0] >> sh;
	assign my_full   = wy_s1[WORLD_W-2:0] >> sh;
	assign sub_mask  = SUB_W'((5'd1 << sh) - 5'd1);
	assign frame_full = FRAME_PROD_W'(sy_s1) * FRAME_PROD_W'(SCREEN_WIDTH)
		+ FRAME_PROD_W'(sx_s1);

	pix_ctl_t               ctl_s2;
	logic [MAP_DIM_W-1:0]   mx_s2;
	logic [MAP_IDX_W-1:0]   row_base_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2.act   <= ctl_s1.act;
			ctl_s2.hit   <= (ctl_s1.act == ACT_RENDER) && on_screen && x_inside && y_inside;
			ctl_s2.addr  <= ctl_s1.addr;
			ctl_s2.data  <= ctl_s1.data;
			ctl_s2.px    <= wx_s1[SUB_W-1:0] & sub_mask;
			ctl_s2.py    <= wy_s1[SUB_W-1:0] & sub_mask;
			ctl_s2.frame <= frame_full[FRAME_W-1:0];
			mx_s2        <= mx_full[MAP_DIM_W-1:0];
			// Inside the map the tile row is below map_rows, so 13 bits hold it.
			row_base_s2  <= MAP_IDX_W'(my_full[MAP_DIM_W-1:0]) * MAP_IDX_W'(map_columns_q);
		end
	end

	// Stage 3: map index (or write address) and its quotient estimate.
	logic [MAP_IDX_W-1:0] map_x;
	logic [MapProdW-1:0]  map_qprod;

	assign map_x = (ctl_s2.act == ACT_MAP_WRITE) ? MAP_IDX_W'(ctl_s2.addr)
		: row_base_s2 + MAP_IDX_W'(mx_s2);
	assign map_qprod = MapProdW'(map_x) * MapProdW'(MapRecip);

	pix_ctl_t              ctl_s3;
	logic [MAP_IDX_W-1:0]  map_x_s3;
	logic [MapRecipW-1:0]  map_q_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3   <= ctl_s2;
			map_x_s3 <= map_x;
			map_q_s3 <= map_qprod[MapProdW-1:MAP_IDX_W];
		end
	end

	// Stage 4: remainder, below twice the store depth.
	logic [MAP_IDX_W:0] map_r_full;
	assign map_r_full = (MAP_IDX_W + 1)'(map_x_s3)
		- (MAP_IDX_W + 1)'(map_q_s3) * (MAP_IDX_W + 1)'(MAP_ENTRIES);

	pix_ctl_t        ctl_s4;
	logic [MapAw:0]  map_r_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4   <= ctl_s3;
			map_r_s4 <= map_r_full[MapAw:0];
		end
	end

	// Map store access: the write of a map load and the read of a render happen at the
	// same stage, so they keep the order of the input words.
	logic [MapAw:0]          map_r_red;
	logic [MapAw-1:0]        map_addr;
	logic [TILE_NUM_W-1:0]   map_mem [MAP_ENTRIES];
	logic [TILE_NUM_W-1:0]   map_rd_s5;

	assign map_r_red = map_r_s4 - MapDepth;
	assign map_addr  = (map_r_s4 >= MapDepth) ? map_r_red[MapAw-1:0] : map_r_s4[MapAw-1:0];

	always_ff @(posedge clk) begin
		if (en && stage_valid_q[3] && ctl_s4.act == ACT_MAP_WRITE) begin
			map_mem[map_addr] <= ctl_s4.data[TILE_NUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			map_rd_s5 <= map_mem[map_addr];
		end
	end

	pix_ctl_t ctl_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s5 <= ctl_s4;
		end
	end

	// Stage 6: tile pixel index (or write address) and its quotient estimate.
	logic [TILE_IDX_W-1:0] tile_x;
	logic [TileProdW-1:0]  tile_qprod;

	assign tile_x = (ctl_s5.act == ACT_TILE_WRITE) ? ctl_s5.addr
		: (TILE_IDX_W'(map_rd_s5) << {sh, 1'b0}) + (TILE_IDX_W'(ctl_s5.py) << sh)
		+ TILE_IDX_W'(ctl_s5.px);
	assign tile_qprod = TileProdW'(tile_x) * TileProdW'(TileRecip);

	pix_ctl_t               ctl_s6;
	logic [TILE_IDX_W-1:0]  tile_x_s6;
	logic [TileRecipW-1:0]  tile_q_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s6    <= ctl_s5;
			tile_x_s6 <= tile_x;
			tile_q_s6 <= tile_qprod[TileProdW-1:TILE_IDX_W];
		end
	end

	// Stage 7: remainder, below twice the store depth.
	logic [TILE_IDX_W:0] tile_r_full;
	assign tile_r_full = (TILE_IDX_W + 1)'(tile_x_s6)
		- (TILE_IDX_W + 1)'(tile_q_s6) * (TILE_IDX_W + 1)'(TILE_WORDS);

	pix_ctl_t         ctl_s7;
	logic [TileAw:0]  tile_r_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s7    <= ctl_s6;
			tile_r_s7 <= tile_r_full[TileAw:0];
		end
	end

	// Tile pixel store access, ordered in the same way as the map store.
	logic [TileAw:0]       tile_r_red;
	logic [TileAw-1:0]     tile_addr;
	logic [COLOR_W-1:0]    tile_mem [TILE_WORDS];
	logic [COLOR_W-1:0]    tile_rd_s8;

	assign tile_r_red = tile_r_s7 - TileDepth;
	assign tile_addr  = (tile_r_s7 >= TileDepth) ? tile_r_red[TileAw-1:0]
		: tile_r_s7[TileAw-1:0];

	always_ff @(posedge clk) begin
		if (en && stage_valid_q[6] && ctl_s7.act == ACT_TILE_WRITE) begin
			tile_mem[tile_addr] <= ctl_s7.data;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tile_rd_s8 <= tile_mem[tile_addr];
		end
	end

	pix_ctl_t ctl_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s8 <= ctl_s7;
		end
	end

	// Result of the word leaving the last stage: zero unless it is a render hit.
	logic               res_fire;
	logic [COLOR_W-1:0] res_color;
	logic [FRAME_W-1:0] res_frame;

	assign res_fire  = en && stage_valid_q[Stages-1];
	assign res_color = ctl_s8.hit ? tile_rd_s8 : '0;
	assign res_frame = ctl_s8.hit ? ctl_s8.frame : '0;

	// Output register with a skid register behind it. The output register is refilled
	// from the skid register first, so words leave in order.
	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic               out_we_q;
	logic [COLOR_W-1:0] skid_color_q;
	logic [FRAME_W-1:0] skid_frame_q;
	logic               skid_we_q;
	logic               out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_fire;
			end
		end else if (res_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_color_q <= skid_color_q;
				out_frame_q <= skid_frame_q;
				out_we_q    <= skid_we_q;
			end else if (res_fire) begin
				out_color_q <= res_color;
				out_frame_q <= res_frame;
				out_we_q    <= ctl_s8.hit;
			end
		end else if (res_fire) begin
			skid_color_q <= res_color;
			skid_frame_q <= res_frame;
			skid_we_q    <= ctl_s8.hit;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_color   = out_color_q;
	assign frame_address = out_frame_q;
	assign write_enable  = out_we_q;

endmodule
